// ----- rtl/assert_macros.svh -----
// Shared assertion macros for the deframer checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lpwd_pkg.sv -----
`default_nettype none

package lpwd_pkg;

    localparam int unsigned LEN_W      = 32;
    localparam int unsigned SKIP_W     = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned LEN_CNT_W  = 2;

    localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 32'd2097152;
    localparam logic [SKIP_W-1:0] HDR_SKIP_RST = 8'd44;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } t_phase;

    typedef enum logic [0:0] {
        CFG_MAX_FRAME_LEN = 1'b0,
        CFG_HEADER_SKIP   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                       sample_valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_done;
        logic                       bad_length;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ----- rtl/lpwd_front.sv -----
`default_nettype none

module lpwd_front
    import lpwd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_abort,
    input  wire logic              i_cfg_we,
    input  wire t_cfg_idx          i_cfg_index,
    input  wire logic [LEN_W-1:0]  i_cfg_wdata,
    output t_q_push                o_push
);

    t_phase                 r_phase, n_phase;
    logic [LEN_W-1:0]       r_max_len;
    logic [SKIP_W-1:0]      r_hdr_skip;
    logic [LEN_W-1:0]       r_len_acc, n_len_acc;
    logic [LEN_CNT_W-1:0]   r_len_cnt, n_len_cnt;
    logic [LEN_W-1:0]       r_remaining, n_remaining;
    logic [SKIP_W-1:0]      r_hdr_cnt, n_hdr_cnt;
    logic [BYTE_W-1:0]      r_low_hold, n_low_hold;
    logic                   r_low_held, n_low_held;

    logic [LEN_W-1:0]       w_acc_new;
    logic                   w_len_last;
    logic                   w_len_bad;
    logic [LEN_W-1:0]       w_rem_dec;
    logic                   w_pay_last;
    logic                   w_in_header;

    assign w_acc_new   = {r_len_acc[LEN_W-BYTE_W-1:0], i_data_byte};
    assign w_len_last  = (r_len_cnt == '1);
    assign w_len_bad   = (w_acc_new == '0) || (w_acc_new > r_max_len);
    assign w_rem_dec   = r_remaining - LEN_W'(1);
    assign w_pay_last  = (w_rem_dec == '0);
    assign w_in_header = (r_hdr_cnt < r_hdr_skip);

    // Configuration registers; a write takes effect once it is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_LEN_RST;
            r_hdr_skip <= HDR_SKIP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_FRAME_LEN: r_max_len  <= i_cfg_wdata;
                CFG_HEADER_SKIP:   r_hdr_skip <= i_cfg_wdata[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_take) begin
            if (i_abort) begin
                n_phase = PH_LENGTH;
            end else begin
                case (r_phase)
                    PH_LENGTH: begin
                        if (w_len_last) begin
                            n_phase = w_len_bad ? PH_HALTED : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (w_pay_last) begin
                            n_phase = PH_LENGTH;
                        end
                    end
                    PH_HALTED: n_phase = PH_HALTED;
                    default:   n_phase = PH_LENGTH;
                endcase
            end
        end
    end

    // Datapath and result classification.
    always_comb begin
        n_len_acc   = r_len_acc;
        n_len_cnt   = r_len_cnt;
        n_remaining = r_remaining;
        n_hdr_cnt   = r_hdr_cnt;
        n_low_hold  = r_low_hold;
        n_low_held  = r_low_held;
        o_push      = '0;
        if (i_take) begin
            if (i_abort) begin
                n_len_acc   = '0;
                n_len_cnt   = '0;
                n_remaining = '0;
                n_hdr_cnt   = '0;
                n_low_hold  = '0;
                n_low_held  = 1'b0;
            end else begin
                case (r_phase)
                    PH_LENGTH: begin
                        n_len_acc = w_acc_new;
                        n_len_cnt = r_len_cnt + LEN_CNT_W'(1);
                        if (w_len_last) begin
                            if (w_len_bad) begin
                                o_push.valid           = 1'b1;
                                o_push.data.bad_length = 1'b1;
                            end else begin
                                n_remaining = w_acc_new;
                                n_len_acc   = '0;
                                n_hdr_cnt   = '0;
                                n_low_hold  = '0;
                                n_low_held  = 1'b0;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_remaining = w_rem_dec;
                        if (w_in_header) begin
                            n_hdr_cnt = r_hdr_cnt + SKIP_W'(1);
                        end else if (!r_low_held) begin
                            n_low_hold = i_data_byte;
                            n_low_held = 1'b1;
                        end else begin
                            o_push.valid             = 1'b1;
                            o_push.data.sample_valid = 1'b1;
                            o_push.data.sample       = {i_data_byte, r_low_hold};
                            n_low_hold               = '0;
                            n_low_held               = 1'b0;
                        end
                        if (w_pay_last) begin
                            o_push.valid           = 1'b1;
                            o_push.data.frame_done = 1'b1;
                            n_len_acc   = '0;
                            n_len_cnt   = '0;
                            n_remaining = '0;
                            n_hdr_cnt   = '0;
                            n_low_hold  = '0;
                            n_low_held  = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LENGTH;
            r_len_acc   <= '0;
            r_len_cnt   <= '0;
            r_remaining <= '0;
            r_hdr_cnt   <= '0;
            r_low_hold  <= '0;
            r_low_held  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len_acc   <= n_len_acc;
            r_len_cnt   <= n_len_cnt;
            r_remaining <= n_remaining;
            r_hdr_cnt   <= n_hdr_cnt;
            r_low_hold  <= n_low_hold;
            r_low_held  <= n_low_held;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lpwd_queue.sv -----
`default_nettype none

module lpwd_queue
    import lpwd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_push i_push,
    input  wire logic    i_pop,
    output t_result      o_pop_data,
    output t_q_status    o_status
);

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == QCW'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push.valid && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QAW'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + QAW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + QCW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lpwd_back.sv -----
`default_nettype none

module lpwd_back
    import lpwd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_status,
    input  wire t_result   i_data,
    output logic           o_pop,
    output logic           o_tvalid,
    input  wire logic      i_tready,
    output t_result        o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_pop    = !i_status.empty && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_wav_deframer_core.sv -----
// Length-prefixed WAV deframer.
// Input stream (s_axis): one byte of the response stream per transaction in
// tdata[7:0]; tuser[0] is an abort flag that drops the byte and returns the
// parser to waiting for a 4-byte big-endian length.
// Output stream (m_axis): at most one transaction per input byte. tdata carries
// the stereo pair (left in [15:0], right in [31:16]), tuser[0] marks a sample,
// tuser[1] a bad frame length, and tlast the last byte of a frame.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 = maximum frame length, 1 = WAV header bytes skipped per frame).
// Throughput is one byte per cycle while the queue has room. The parser in the
// front part finishes each byte in the cycle it is accepted; a result then
// passes through a four-entry queue and an output register before it is
// offered on m_axis.
// Synchronous active-low reset returns the parser to waiting for a length and
// the registers to their defaults (2 MiB maximum, 44-byte header).
// When the receiver stalls, results collect in the queue; once it is full,
// s_axis_tready drops until the receiver takes a result.
`default_nettype none

module length_prefixed_wav_deframer_core
    import lpwd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input byte stream.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]        s_axis_tuser,   // [0] abort
    // Result stream.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic [1:0]             m_axis_tuser,   // [0] sample_valid, [1] bad_length
    output logic                   m_axis_tlast,   // frame_done
    // Configuration write port.
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [LEN_W-1:0]  i_cfg_wdata
);

    t_q_push   w_push;
    t_q_status w_status;
    t_result   w_q_data;
    t_result   w_out;
    logic      w_pop;
    logic      w_take;

    // The front part stalls only when the queue has no room for a result.
    assign s_axis_tready = !w_status.full;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    lpwd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_data_byte (s_axis_tdata),
        .i_abort     (s_axis_tuser[0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (w_push)
    );

    lpwd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_pop      (w_pop),
        .o_pop_data (w_q_data),
        .o_status   (w_status)
    );

    lpwd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .i_data   (w_q_data),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_result (w_out)
    );

    // The mono sample is copied to both channels.
    assign m_axis_tdata = {w_out.sample, w_out.sample};
    assign m_axis_tuser = {w_out.bad_length, w_out.sample_valid};
    assign m_axis_tlast = w_out.frame_done;

endmodule

`default_nettype wire

// ----- rtl/lpwd_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module lpwd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `ASSERT_IMPLY(a_not_empty, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[0] || m_axis_tuser[1] || m_axis_tlast, "result carries no flag")
    `ASSERT_IMPLY(a_bad_alone, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0] && !m_axis_tlast && (m_axis_tdata == 32'd0), "bad length result not clean")
    `ASSERT_IMPLY(a_stereo_copy, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[15:0] == m_axis_tdata[31:16]) && (m_axis_tuser[0] || (m_axis_tdata == 32'd0)), "channel mismatch or stray sample")

endmodule

bind length_prefixed_wav_deframer_core lpwd_checker u_lpwd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
